>>> hw/rtl/fsme_pkg.sv
`timescale 1ns / 1ps

package fsme_pkg;

	// Field widths of the item and result channels.
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned DEP_W      = 32;
	localparam int unsigned JOBNUM_W   = 8;

	// Configuration port and register widths.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned MCOUNT_W   = 5;
	localparam int unsigned JCOUNT_W   = 9;

	typedef logic [DEP_W-1:0]     dep_t;
	typedef logic [TIME_W-1:0]    ptime_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [MODE_W-1:0]    shop_mode_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_SHOP_MODE     = 2'd0;
	localparam cfg_idx_t CFG_MACHINE_COUNT = 2'd1;
	localparam cfg_idx_t CFG_JOB_COUNT     = 2'd2;

	// Shop modes; the unused code behaves as unlimited buffers.
	localparam shop_mode_t MODE_UNLIMITED = 2'd0;
	localparam shop_mode_t MODE_BLOCKING  = 2'd1;
	localparam shop_mode_t MODE_NO_WAIT   = 2'd2;

	// Sequencer states, one per step of the shared adder and comparator.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_M,
		ST_RD_N,
		ST_LD_N,
		ST_GAP,
		ST_OFF,
		ST_SUM,
		ST_MAX,
		ST_WR
	} fsme_state_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_go;
		logic last_machine;
		logic out_blocked;
	} fsme_status_t;

	// Step strobes from the sequencer to the datapath.
	typedef struct packed {
		logic busy;
		logic ram_rd;
		logic rd_next;
		logic ld_pm;
		logic ld_pn;
		logic ld_gap;
		logic ld_off;
		logic ld_sum;
		logic ld_max;
		logic commit;
	} fsme_ctrl_t;

endpackage

>>> hw/rtl/fsme_ctrl.sv
`timescale 1ns / 1ps

module fsme_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsme_pkg::fsme_status_t status,
	output fsme_pkg::fsme_ctrl_t   ctrl
);

	fsme_pkg::fsme_state_t state_q;
	fsme_pkg::fsme_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a fixed walk through the steps, holding at write-back while the
	// last-machine result cannot enter the output register.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsme_pkg::ST_IDLE: begin
				if (status.in_go) begin
					state_d = fsme_pkg::ST_RD_M;
				end
			end
			fsme_pkg::ST_RD_M: state_d = fsme_pkg::ST_RD_N;
			fsme_pkg::ST_RD_N: state_d = fsme_pkg::ST_LD_N;
			fsme_pkg::ST_LD_N: state_d = fsme_pkg::ST_GAP;
			fsme_pkg::ST_GAP:  state_d = fsme_pkg::ST_OFF;
			fsme_pkg::ST_OFF:  state_d = fsme_pkg::ST_SUM;
			fsme_pkg::ST_SUM:  state_d = fsme_pkg::ST_MAX;
			fsme_pkg::ST_MAX:  state_d = fsme_pkg::ST_WR;
			fsme_pkg::ST_WR: begin
				if (!(status.last_machine && status.out_blocked)) begin
					state_d = fsme_pkg::ST_IDLE;
				end
			end
			default: state_d = fsme_pkg::ST_IDLE;
		endcase
	end

	// Step strobes decoded from the state.
	always_comb begin
		ctrl         = '0;
		ctrl.busy    = (state_q != fsme_pkg::ST_IDLE);
		ctrl.ram_rd  = (state_q == fsme_pkg::ST_RD_M) || (state_q == fsme_pkg::ST_RD_N);
		ctrl.rd_next = (state_q == fsme_pkg::ST_RD_N);
		ctrl.ld_pm   = (state_q == fsme_pkg::ST_RD_N);
		ctrl.ld_pn   = (state_q == fsme_pkg::ST_LD_N);
		ctrl.ld_gap  = (state_q == fsme_pkg::ST_GAP);
		ctrl.ld_off  = (state_q == fsme_pkg::ST_OFF);
		ctrl.ld_sum  = (state_q == fsme_pkg::ST_SUM);
		ctrl.ld_max  = (state_q == fsme_pkg::ST_MAX);
		ctrl.commit  = (state_q == fsme_pkg::ST_WR) &&
		               !(status.last_machine && status.out_blocked);
	end

endmodule

>>> hw/rtl/flow_shop_makespan_eval.sv
`timescale 1ns / 1ps

// Permutation flow shop departure evaluator. Processing times arrive one item
// at a time, machine 0 first, for each job of the sequence in turn; after the
// last machine of a job the block delivers that job's last-machine departure,
// its position in the sequence and a flag marking the final job, whose
// departure is the makespan. Modes are unlimited buffers, blocking and no-wait.
// Each item is finished, from acceptance on, before the block takes the next
// one: a small sequencer steps a single shared 32-bit adder and comparator
// through two reads of the previous departure column, the no-wait gap, the
// offset update, the sum, the blocking maximum and the write-back. A result
// that finds the output register still occupied holds the sequencer at
// write-back until it is taken. The departure columns live in a ping-pong
// memory of two banks; no-wait shifts of earlier machines are kept as a running
// column offset, so the job switch is a bank flip and no clearing pass is
// needed after reset. Any register write restarts the sequence at job 0,
// machine 0.
module flow_shop_makespan_eval #(
	parameter int MAX_MACHINES = 16,
	parameter int MAX_JOBS     = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Item channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fsme_pkg::TIME_W-1:0]       proc_time,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fsme_pkg::DEP_W-1:0]        job_departure,
	output logic [fsme_pkg::JOBNUM_W-1:0]     job_number,
	output logic                              is_makespan,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fsme_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsme_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int MW        = $clog2(MAX_MACHINES);
	localparam int AW        = MW + 1;
	localparam int RAM_DEPTH = 1 << AW;
	localparam int NMW       = $clog2(MAX_MACHINES + 1);
	localparam int JW        = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int NJW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS + 1) : 1;
	localparam int JXW       = (JW > fsme_pkg::JOBNUM_W) ? JW : fsme_pkg::JOBNUM_W;

	fsme_pkg::fsme_ctrl_t   ctrl;
	fsme_pkg::fsme_status_t status;

	// Configuration registers.
	fsme_pkg::shop_mode_t            mode_q;
	logic [fsme_pkg::MCOUNT_W-1:0]   mcount_q;
	logic [fsme_pkg::JCOUNT_W-1:0]   jcount_q;

	// Sequence position and column bookkeeping.
	logic [MW-1:0]   mpos_q;
	logic [JW-1:0]   jpos_q;
	logic            bank_q;
	fsme_pkg::dep_t  cur_off_q;
	fsme_pkg::dep_t  prev_off_q;

	// Per-item working registers.
	fsme_pkg::ptime_t p_q;
	fsme_pkg::dep_t   pm_q;
	fsme_pkg::dep_t   pn_q;
	fsme_pkg::dep_t   gap_q;
	fsme_pkg::dep_t   base_q;
	fsme_pkg::dep_t   sum_q;
	fsme_pkg::dep_t   d_q;
	fsme_pkg::dep_t   last_d_q;
	logic             shift_q;

	// Output register.
	logic                          out_valid_q;
	fsme_pkg::dep_t                out_dep_q;
	logic [fsme_pkg::JOBNUM_W-1:0] out_job_q;
	logic                          out_last_q;

	// Column memory, two banks of MAX_MACHINES entries rounded up to a power of two.
	fsme_pkg::dep_t col_mem [RAM_DEPTH];
	fsme_pkg::dep_t ram_rdata_q;
	logic [AW-1:0]  ram_raddr;
	logic [AW-1:0]  ram_waddr;
	logic [MW-1:0]  rd_idx;

	logic [NMW-1:0] nm_used;
	logic [NJW-1:0] nj_used;
	logic           first_job;
	logic           first_machine;
	logic           last_machine;
	logic           last_job;
	logic           is_blk;
	logic           is_nw;
	logic           cfg_wr;
	logic           cfg_restart;
	logic [JXW-1:0] jpos_ext;

	fsme_pkg::dep_t alu_a;
	fsme_pkg::dep_t alu_b;
	logic           alu_sub;
	fsme_pkg::dep_t alu_y;
	fsme_pkg::dep_t cmp_a;
	fsme_pkg::dep_t cmp_b;
	logic           cmp_lt;
	fsme_pkg::dep_t base_c;

	// Handshake outputs.
	assign in_stall  = ctrl.busy;
	assign cfg_ready = !ctrl.busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign status.in_go        = in_valid && !ctrl.busy;
	assign status.last_machine = last_machine;
	assign status.out_blocked  = out_valid_q && out_stall;

	fsme_ctrl u_fsme_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Effective machine and job counts, clamped to the supported range.
	always_comb begin
		if (mcount_q < fsme_pkg::MCOUNT_W'(2)) begin
			nm_used = NMW'(2);
		end else if (32'(mcount_q) > MAX_MACHINES) begin
			nm_used = NMW'(MAX_MACHINES);
		end else begin
			nm_used = NMW'(mcount_q);
		end
		if (jcount_q == '0) begin
			nj_used = NJW'(1);
		end else if (32'(jcount_q) > MAX_JOBS) begin
			nj_used = NJW'(MAX_JOBS);
		end else begin
			nj_used = NJW'(jcount_q);
		end
	end

	assign first_job     = (jpos_q == '0);
	assign first_machine = (mpos_q == '0);
	assign last_machine  = ((NMW'(mpos_q) + NMW'(1)) == nm_used);
	assign last_job      = ((NJW'(jpos_q) + NJW'(1)) == nj_used);
	assign is_blk        = (mode_q == fsme_pkg::MODE_BLOCKING);
	assign is_nw         = (mode_q == fsme_pkg::MODE_NO_WAIT);
	assign jpos_ext      = JXW'(jpos_q);

	// Configuration writes; a write to a known register restarts the sequence.
	always_comb begin
		cfg_restart = 1'b0;
		if (cfg_wr) begin
			unique case (cfg_index)
				fsme_pkg::CFG_SHOP_MODE:     cfg_restart = 1'b1;
				fsme_pkg::CFG_MACHINE_COUNT: cfg_restart = 1'b1;
				fsme_pkg::CFG_JOB_COUNT:     cfg_restart = 1'b1;
				default:                     cfg_restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= fsme_pkg::MODE_UNLIMITED;
			mcount_q <= fsme_pkg::MCOUNT_W'(2);
			jcount_q <= fsme_pkg::JCOUNT_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				fsme_pkg::CFG_SHOP_MODE:     mode_q   <= cfg_data[fsme_pkg::MODE_W-1:0];
				fsme_pkg::CFG_MACHINE_COUNT: mcount_q <= cfg_data[fsme_pkg::MCOUNT_W-1:0];
				fsme_pkg::CFG_JOB_COUNT:     jcount_q <= cfg_data[fsme_pkg::JCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Shared adder: operands chosen by the current step.
	always_comb begin
		alu_a   = ram_rdata_q;
		alu_b   = prev_off_q;
		alu_sub = 1'b0;
		if (ctrl.ld_gap) begin
			alu_a   = pm_q;
			alu_b   = last_d_q;
			alu_sub = 1'b1;
		end else if (ctrl.ld_off) begin
			alu_a = cur_off_q;
			alu_b = gap_q;
		end else if (ctrl.ld_sum) begin
			alu_a = base_q;
			alu_b = fsme_pkg::dep_t'(p_q);
		end else if (ctrl.commit) begin
			alu_a   = d_q;
			alu_b   = cur_off_q;
			alu_sub = 1'b1;
		end
		alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	end

	// Shared comparator: gap test, or the blocking maximum.
	always_comb begin
		if (ctrl.ld_max) begin
			cmp_a = sum_q;
			cmp_b = pn_q;
		end else begin
			cmp_a = last_d_q;
			cmp_b = pm_q;
		end
		cmp_lt = (cmp_a < cmp_b);
	end

	// Start value that the processing time is added to.
	always_comb begin
		if (first_job) begin
			base_c = first_machine ? '0 : last_d_q;
		end else if (first_machine) begin
			base_c = pm_q;
		end else if (is_blk) begin
			base_c = last_d_q;
		end else begin
			base_c = cmp_lt ? pm_q : last_d_q;
		end
	end

	// Column memory: previous column is read from the current bank, the job
	// being built is written to the other one, stored less the column offset.
	assign rd_idx    = ctrl.rd_next ? (mpos_q + MW'(1)) : mpos_q;
	assign ram_raddr = {bank_q, rd_idx};
	assign ram_waddr = {~bank_q, mpos_q};

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			col_mem[ram_waddr] <= alu_y;
		end
		if (ctrl.ram_rd) begin
			ram_rdata_q <= col_mem[ram_raddr];
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (status.in_go) begin
			p_q <= proc_time;
		end
		if (ctrl.ld_pm) begin
			pm_q <= alu_y;
		end
		if (ctrl.ld_pn) begin
			pn_q <= alu_y;
		end
		if (ctrl.ld_gap) begin
			gap_q   <= alu_y;
			base_q  <= base_c;
			shift_q <= is_nw && !first_job && !first_machine && cmp_lt;
		end
		if (ctrl.ld_sum) begin
			sum_q <= alu_y;
		end
		if (ctrl.ld_max) begin
			if (is_blk && !first_job && !last_machine && cmp_lt) begin
				d_q <= pn_q;
			end else begin
				d_q <= sum_q;
			end
		end
		if (ctrl.commit) begin
			last_d_q <= d_q;
		end
	end

	// Sequence position, bank select and column offsets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpos_q     <= '0;
			jpos_q     <= '0;
			bank_q     <= 1'b0;
			cur_off_q  <= '0;
			prev_off_q <= '0;
		end else if (cfg_restart) begin
			mpos_q    <= '0;
			jpos_q    <= '0;
			cur_off_q <= '0;
		end else if (ctrl.ld_off) begin
			if (shift_q) begin
				cur_off_q <= alu_y;
			end
		end else if (ctrl.commit) begin
			if (last_machine) begin
				mpos_q     <= '0;
				jpos_q     <= last_job ? '0 : (jpos_q + JW'(1));
				bank_q     <= ~bank_q;
				prev_off_q <= cur_off_q;
				cur_off_q  <= '0;
			end else begin
				mpos_q <= mpos_q + MW'(1);
			end
		end
	end

	// Output register: loaded at the last machine of a job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit && last_machine) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit && last_machine) begin
			out_dep_q  <= d_q;
			out_job_q  <= jpos_ext[fsme_pkg::JOBNUM_W-1:0];
			out_last_q <= last_job;
		end
	end

	assign out_valid     = out_valid_q;
	assign job_departure = out_dep_q;
	assign job_number    = out_job_q;
	assign is_makespan   = out_last_q;

endmodule

>>> hw/rtl/fsme_checker.sv
`timescale 1ns / 1ps

module fsme_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [fsme_pkg::DEP_W-1:0]      job_departure,
	input logic [fsme_pkg::JOBNUM_W-1:0]   job_number,
	input logic                            is_makespan,
	input logic                            cfg_ready
);

	// An accepted item keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall
	) else $error("item channel open right after an item was accepted");

	// Configuration is only taken while no item is in work.
	a_cfg_only_idle: assert property (
		@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !in_stall
	) else $error("configuration ready while an item is in work");

	// A new result only appears out of an item that was in work.
	a_result_from_work: assert property (
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall)
	) else $error("result appeared with no item in work");

	// A stalled result holds.
	a_result_holds: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(job_departure) &&
			$stable(job_number) && $stable(is_makespan))
	) else $error("stalled result changed or dropped");

endmodule

bind flow_shop_makespan_eval fsme_checker u_fsme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.job_departure (job_departure),
	.job_number    (job_number),
	.is_makespan   (is_makespan),
	.cfg_ready     (cfg_ready)
);
